[rtl/pwt_pkg.sv]
// Package for the per-window timer table: sizes, command/kind/status codes,
// and the entry and result types. No dependencies.
package pwt_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
    localparam int TIME_BITS  = 32;
    localparam int WIN_W      = 16;
    localparam int IV_W       = 32;

    // item commands
    localparam logic [1:0] CMD_SET  = 2'd0;
    localparam logic [1:0] CMD_GET  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SET = 2'd0;
    localparam logic [1:0] KIND_GET = 2'd1;
    localparam logic [1:0] KIND_EXP = 2'd2;

    // result status
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_NULL = 2'd1;
    localparam logic [1:0] STS_FULL = 2'd2;

    typedef struct packed {
        logic [WIN_W-1:0]     win;
        logic [IV_W-1:0]      iv;
        logic [TIME_BITS-1:0] start;
    } t_entry;

    typedef struct packed {
        logic [1:0]       kind;
        logic [WIN_W-1:0] win;
        logic [IV_W-1:0]  iv;
        logic [1:0]       status;
        logic             last;
    } t_result;

endpackage

[rtl/pwt_in_if.sv]
// Input item channel of the timer table: valid/ready plus command fields.
// Depends on nothing.
interface pwt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] window_id;
    logic [31:0] interval_ms;
    logic [31:0] now_ms;

    modport source (output valid, cmd, window_id, interval_ms, now_ms, input ready);
    modport sink   (input valid, cmd, window_id, interval_ms, now_ms, output ready);
endinterface

[rtl/pwt_out_if.sv]
// Result item channel of the timer table: valid/ready plus result fields.
// Depends on nothing.
interface pwt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] out_window;
    logic [31:0] out_interval;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, kind, out_window, out_interval, status, last, input ready);
    modport sink   (input valid, kind, out_window, out_interval, status, last, output ready);
endinterface

[rtl/per_window_timer_table.sv]
// Per-window periodic timer table. Entries (window, interval, start time) live in
// one synchronous RAM; valid bits and recency ranks sit in flops. One item is
// worked at a time. Set and get scan all MAX_TIMERS entries, one RAM read per
// cycle, then drain the read pipe and update; a null window skips the scan. A
// tick reads the valid entries in recency order, one per cycle while the result
// port does not stall. Expiries are held one deep so the final one can carry
// last. Depends on pwt_pkg, pwt_in_if and pwt_out_if.
module per_window_timer_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pwt_in_if.sink    i_in,
    pwt_out_if.source o_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FIND = 2'd1;
    localparam logic [1:0] ST_ACT  = 2'd2;
    localparam logic [1:0] ST_TICK = 2'd3;

    localparam int N  = pwt_pkg::MAX_TIMERS;
    localparam int IW = pwt_pkg::IDX_W;
    localparam int CW = pwt_pkg::CNT_W;
    localparam int TW = pwt_pkg::TIME_BITS;

    // entry RAM
    pwt_pkg::t_entry mem [N];
    pwt_pkg::t_entry r_rd;

    logic [1:0]     r_state;
    logic [N-1:0]   r_valid;
    logic [IW-1:0]  r_rank_tab [N];
    logic [CW-1:0]  r_cnt;
    logic           r_rd_vld;
    logic [IW-1:0]  r_rd_idx;
    logic           r_found;
    logic [IW-1:0]  r_fidx;
    pwt_pkg::t_entry r_fdata;
    logic           r_null;
    logic [1:0]     r_cmd;
    logic [15:0]    r_win;
    logic [31:0]    r_iv;
    logic [TW-1:0]  r_now;
    logic           r_hold_vld;
    pwt_pkg::t_result r_hold;
    logic           r_out_vld;
    pwt_pkg::t_result r_out;

    logic           out_can_load;
    logic           out_load;
    logic           rd_en;
    logic [IW-1:0]  rd_addr;
    logic           we;
    logic [IW-1:0]  waddr;
    pwt_pkg::t_entry wdata;
    logic           rank_hit;
    logic [IW-1:0]  rank_idx;
    logic           more;
    logic [TW-1:0]  due;
    logic           expired;
    logic           take;
    logic           tick_done;
    logic           free_hit;
    logic [IW-1:0]  free_idx;
    logic           act_fire;
    logic           accept;
    pwt_pkg::t_result act_res;

    assign out_can_load = !r_out_vld || o_out.ready;
    assign i_in.ready   = (r_state == ST_IDLE);
    assign accept       = i_in.valid && i_in.ready;

    // entry of the rank now being visited
    always_comb begin
        rank_hit = 1'b0;
        rank_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (!rank_hit && r_valid[i] && r_rank_tab[i] == r_cnt[IW-1:0]) begin
                rank_hit = 1'b1;
                rank_idx = IW'(i);
            end
        end
    end

    // first free slot
    always_comb begin
        free_hit = 1'b0;
        free_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (!free_hit && !r_valid[i]) begin
                free_hit = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign more      = (r_cnt < CW'(N)) && rank_hit;
    assign due       = r_rd.start + TW'(r_rd.iv);
    assign expired   = (due <= r_now);
    assign take      = r_rd_vld && !(expired && r_hold_vld && !out_can_load);
    assign tick_done = (r_state == ST_TICK) && !r_rd_vld && !more;
    assign act_fire  = (r_state == ST_ACT) && out_can_load;

    // output register loads: set/get answer, pushed expiry, final expiry
    assign out_load  = act_fire ||
                       ((r_state == ST_TICK) && take && expired && r_hold_vld) ||
                       (tick_done && r_hold_vld && out_can_load);

    // RAM read address and enable
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (r_state)
            ST_FIND: begin
                rd_en   = (r_cnt < CW'(N));
                rd_addr = r_cnt[IW-1:0];
            end
            ST_TICK: begin
                rd_en   = more && (!r_rd_vld || take);
                rd_addr = rank_idx;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // write-back and the set/get result
    always_comb begin
        we      = 1'b0;
        waddr   = '0;
        wdata   = r_fdata;
        act_res = '{kind: (r_cmd == pwt_pkg::CMD_SET) ? pwt_pkg::KIND_SET : pwt_pkg::KIND_GET,
                    win: r_win, iv: r_iv, status: pwt_pkg::STS_OK, last: 1'b1};
        if (r_state == ST_TICK) begin
            we          = take && expired;
            waddr       = r_rd_idx;
            wdata       = r_rd;
            wdata.start = r_now;
        end else if (act_fire) begin
            priority if (r_null) begin
                act_res.win    = '0;
                act_res.iv     = '0;
                act_res.status = pwt_pkg::STS_NULL;
            end else if (r_cmd == pwt_pkg::CMD_GET) begin
                act_res.iv = r_found ? r_fdata.iv : '0;
            end else if (r_iv == '0) begin
                act_res.iv = '0;
            end else if (r_found) begin
                we       = 1'b1;
                waddr    = r_fidx;
                wdata.iv = r_iv;
            end else if (free_hit) begin
                we    = 1'b1;
                waddr = free_idx;
                wdata = '{win: r_win, iv: r_iv, start: r_now};
            end else begin
                act_res.status = pwt_pkg::STS_FULL;
            end
        end
    end

    // RAM
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_rd_vld   <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_found    <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_out_vld <= out_load || (r_out_vld && !o_out.ready);
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt   <= '0;
                    r_found <= 1'b0;
                    if (accept) begin
                        if (i_in.cmd == pwt_pkg::CMD_TICK) begin
                            r_state <= ST_TICK;
                        end else if (i_in.cmd == pwt_pkg::CMD_SET ||
                                     i_in.cmd == pwt_pkg::CMD_GET) begin
                            r_state <= (i_in.window_id == '0) ? ST_ACT : ST_FIND;
                        end
                    end
                end
                ST_FIND: begin
                    if (rd_en) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    r_rd_vld <= rd_en;
                    if (r_rd_vld && r_valid[r_rd_idx] && r_rd.win == r_win) begin
                        r_found <= 1'b1;
                    end
                    if (!r_rd_vld && !rd_en) begin
                        r_state <= ST_ACT;
                    end
                end
                ST_ACT: begin
                    if (act_fire) begin
                        r_state <= ST_IDLE;
                        if (!r_null && r_cmd == pwt_pkg::CMD_SET) begin
                            if (r_iv == '0 && r_found) begin
                                r_valid[r_fidx] <= 1'b0;
                            end else if (!r_found && r_iv != '0 && free_hit) begin
                                r_valid[free_idx] <= 1'b1;
                            end
                        end
                    end
                end
                ST_TICK: begin
                    if (!r_rd_vld || take) begin
                        r_rd_vld <= rd_en;
                    end
                    if (rd_en) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (take && expired) begin
                        r_hold_vld <= 1'b1;
                    end
                    if (tick_done) begin
                        if (!r_hold_vld) begin
                            r_state <= ST_IDLE;
                        end else if (out_can_load) begin
                            r_hold_vld <= 1'b0;
                            r_state    <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload and rank table
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_in.cmd;
            r_win  <= i_in.window_id;
            r_iv   <= i_in.interval_ms;
            r_now  <= i_in.now_ms[TW-1:0];
            r_null <= (i_in.window_id == '0);
        end
        if (rd_en) begin
            r_rd_idx <= rd_addr;
        end
        if (r_state == ST_FIND && r_rd_vld && !r_found &&
            r_valid[r_rd_idx] && r_rd.win == r_win) begin
            r_fidx  <= r_rd_idx;
            r_fdata <= r_rd;
        end
        if (act_fire) begin
            r_out <= act_res;
            if (!r_null && r_cmd == pwt_pkg::CMD_SET) begin
                if (r_iv == '0 && r_found) begin
                    for (int i = 0; i < N; i++) begin
                        if (r_valid[i] && r_rank_tab[i] > r_rank_tab[r_fidx]) begin
                            r_rank_tab[i] <= r_rank_tab[i] - IW'(1);
                        end
                    end
                end else if (!r_found && r_iv != '0 && free_hit) begin
                    for (int i = 0; i < N; i++) begin
                        if (r_valid[i]) begin
                            r_rank_tab[i] <= r_rank_tab[i] + IW'(1);
                        end
                    end
                    r_rank_tab[free_idx] <= '0;
                end
            end
        end
        if (r_state == ST_TICK && take && expired) begin
            r_hold <= '{kind: pwt_pkg::KIND_EXP, win: r_rd.win, iv: r_rd.iv,
                        status: pwt_pkg::STS_OK, last: 1'b0};
            if (r_hold_vld) begin
                r_out <= r_hold;
            end
        end
        if (tick_done && r_hold_vld && out_can_load) begin
            r_out <= '{kind: r_hold.kind, win: r_hold.win, iv: r_hold.iv,
                       status: r_hold.status, last: 1'b1};
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.kind         = r_out.kind;
    assign o_out.out_window   = r_out.win;
    assign o_out.out_interval = r_out.iv;
    assign o_out.status       = r_out.status;
    assign o_out.last         = r_out.last;

    // checks
    a_no_accept_with_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !r_hold_vld) else $error("item accepted with expiry still held");
    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == ST_ACT || r_state == ST_TICK))
        else $error("RAM write outside update states");
    a_hold_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK && take && expired && r_hold_vld) |=> o_out.valid)
        else $error("held expiry not pushed");

endmodule

[tb/per_window_timer_table_chk.sv]
// Checker for the per-window timer table: watches the item and result channels,
// predicts results from its own timer table copy, and compares them in order.
// Depends on pwt_pkg, pwt_in_if and pwt_out_if.
module per_window_timer_table_chk (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pwt_in_if         i_in,
    pwt_out_if        i_out,
    output int        o_errors,
    output int        o_pending
);
    localparam int N  = pwt_pkg::MAX_TIMERS;
    localparam int WW = pwt_pkg::WIN_W;
    localparam int VW = pwt_pkg::IV_W;
    localparam int TW = pwt_pkg::TIME_BITS;

    // shadow timer table
    logic          tbl_used   [N];
    logic [WW-1:0] tbl_win    [N];
    logic [VW-1:0] tbl_iv     [N];
    logic [TW-1:0] tbl_start  [N];
    int            tbl_rank   [N];

    pwt_pkg::t_result expected_results[$];
    int      errors;

    assign o_errors  = errors;
    assign o_pending = expected_results.size();

    task automatic report(input string what);
        errors++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    function automatic pwt_pkg::t_result mk(logic [1:0] kind, logic [WW-1:0] w,
                                            logic [VW-1:0] iv, logic [1:0] st, logic lst);
        pwt_pkg::t_result r;
        r.kind = kind; r.win = w; r.iv = iv; r.status = st; r.last = lst;
        return r;
    endfunction

    function automatic int lookup_window(logic [WW-1:0] w);
        for (int i = 0; i < N; i++)
            if (tbl_used[i] && tbl_win[i] == w) return i;
        return -1;
    endfunction

    // apply one accepted item to the table and queue what it should produce
    task automatic predict_timer_item(logic [1:0] cmd, logic [WW-1:0] w,
                                      logic [VW-1:0] iv, logic [TW-1:0] now);
        int idx;
        int slot;
        int n;
        int pos;
        logic [TW-1:0] due;
        idx = lookup_window(w);
        slot = -1;
        n = 0;
        if (cmd == pwt_pkg::CMD_SET) begin
            if (w == '0) begin
                expected_results.push_back(mk(pwt_pkg::KIND_SET, '0, '0,
                                              pwt_pkg::STS_NULL, 1'b1));
            end else if (iv == '0) begin
                if (idx >= 0) begin
                    for (int i = 0; i < N; i++)
                        if (tbl_used[i] && tbl_rank[i] > tbl_rank[idx]) tbl_rank[i]--;
                    tbl_used[idx] = 1'b0;
                end
                expected_results.push_back(mk(pwt_pkg::KIND_SET, w, '0,
                                              pwt_pkg::STS_OK, 1'b1));
            end else if (idx >= 0) begin
                tbl_iv[idx] = iv;
                expected_results.push_back(mk(pwt_pkg::KIND_SET, w, iv,
                                              pwt_pkg::STS_OK, 1'b1));
            end else begin
                for (int i = N - 1; i >= 0; i--)
                    if (!tbl_used[i]) slot = i;
                if (slot < 0) begin
                    expected_results.push_back(mk(pwt_pkg::KIND_SET, w, iv,
                                                  pwt_pkg::STS_FULL, 1'b1));
                end else begin
                    for (int i = 0; i < N; i++)
                        if (tbl_used[i]) tbl_rank[i]++;
                    tbl_used[slot] = 1'b1;
                    tbl_win[slot] = w;
                    tbl_iv[slot] = iv;
                    tbl_start[slot] = now;
                    tbl_rank[slot] = 0;
                    expected_results.push_back(mk(pwt_pkg::KIND_SET, w, iv,
                                                  pwt_pkg::STS_OK, 1'b1));
                end
            end
        end else if (cmd == pwt_pkg::CMD_GET) begin
            if (w == '0)
                expected_results.push_back(mk(pwt_pkg::KIND_GET, '0, '0,
                                              pwt_pkg::STS_NULL, 1'b1));
            else
                expected_results.push_back(mk(pwt_pkg::KIND_GET, w,
                                              idx >= 0 ? tbl_iv[idx] : '0,
                                              pwt_pkg::STS_OK, 1'b1));
        end else if (cmd == pwt_pkg::CMD_TICK) begin
            // newest first; ranks are dense so stop at the first missing one
            for (int r = 0; r < N; r++) begin
                pos = -1;
                for (int i = 0; i < N; i++)
                    if (tbl_used[i] && tbl_rank[i] == r) pos = i;
                if (pos < 0) break;
                due = tbl_start[pos] + tbl_iv[pos];
                if (due <= now) begin
                    expected_results.push_back(mk(pwt_pkg::KIND_EXP, tbl_win[pos],
                                                  tbl_iv[pos], pwt_pkg::STS_OK, 1'b0));
                    tbl_start[pos] = now;
                    n++;
                end
            end
            if (n > 0) expected_results[$].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        pwt_pkg::t_result exp_r;
        if (!i_rst_n) begin
            errors = 0;
            expected_results.delete();
            for (int i = 0; i < N; i++) begin
                tbl_used[i] = 1'b0;
                tbl_rank[i] = 0;
            end
        end else begin
            // results first: an item accepted now cannot produce one this cycle
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    report($sformatf("unexpected result win=%0d", i_out.out_window));
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_out.kind !== exp_r.kind)
                        report($sformatf("kind %0d, want %0d", i_out.kind, exp_r.kind));
                    if (i_out.out_window !== exp_r.win)
                        report($sformatf("window %0d, want %0d", i_out.out_window,
                                         exp_r.win));
                    if (i_out.out_interval !== exp_r.iv)
                        report($sformatf("interval %0d, want %0d", i_out.out_interval,
                                         exp_r.iv));
                    if (i_out.status !== exp_r.status)
                        report($sformatf("status %0d, want %0d", i_out.status,
                                         exp_r.status));
                    if (i_out.last !== exp_r.last)
                        report($sformatf("last %0b, want %0b", i_out.last, exp_r.last));
                end
            end
            if (i_in.valid && i_in.ready)
                predict_timer_item(i_in.cmd, i_in.window_id, i_in.interval_ms, i_in.now_ms);
        end
    end

endmodule

[tb/per_window_timer_table_tb.sv]
// Top of the timer table testbench: clock, reset, directed and random items,
// result back-pressure and the verdict. Depends on pwt_pkg, the channel
// interfaces, per_window_timer_table and per_window_timer_table_chk.
module per_window_timer_table_tb;

    localparam int STALL_LIMIT = 20000;
    // command value with no meaning; the block drops it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   quiet_cycles;
    logic [31:0] clock_ms;
    logic [15:0] win_pool [8];

    pwt_in_if  in_ch ();
    pwt_out_if out_ch ();

    per_window_timer_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    per_window_timer_table_chk u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // watchdog on channel activity
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("per_window_timer_table_tb NOT OK");
            $finish;
        end
    end

    // present one item, idling first at random, and hold it until accepted
    task automatic send_item(logic [1:0] cmd, logic [15:0] w, logic [31:0] iv,
                             logic [31:0] now);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.window_id   <= w;
        in_ch.interval_ms <= iv;
        in_ch.now_ms      <= now;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // mostly well-formed traffic over a small window pool, with some noise
    task automatic random_items(int count);
        int sel;
        logic [15:0] w;
        logic [31:0] iv;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            w = ($urandom_range(9) == 0) ? 16'($urandom) : win_pool[$urandom_range(7)];
            if ($urandom_range(19) == 0) w = 16'd0;
            iv = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(1, 60));
            clock_ms = clock_ms + $urandom_range(0, 25);
            if (sel < 35)
                send_item(pwt_pkg::CMD_SET, w, ($urandom_range(5) == 0) ? 32'd0 : iv,
                          ($urandom_range(15) == 0) ? $urandom : clock_ms);
            else if (sel < 50)
                send_item(pwt_pkg::CMD_GET, w, $urandom, $urandom);
            else if (sel < 97)
                send_item(pwt_pkg::CMD_TICK, 16'($urandom), $urandom,
                          ($urandom_range(19) == 0) ? $urandom : clock_ms);
            else
                send_item(CMD_UNUSED, 16'($urandom), $urandom, $urandom);
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = pwt_pkg::CMD_GET;
        in_ch.window_id   = '0;
        in_ch.interval_ms = '0;
        in_ch.now_ms      = '0;
        out_ch.ready      = 1'b0;
        quiet_cycles      = 0;
        src_idle_pct      = 23;
        snk_idle_pct      = 88;
        clock_ms          = 32'd1000;
        for (int i = 0; i < 8; i++) win_pool[i] = 16'(i + 1);
        win_pool[7] = 16'hFFFF;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // null window, extremes, update, removal, wrap, unused command
        send_item(pwt_pkg::CMD_SET, 16'd0, 32'd5, 32'd0);
        send_item(pwt_pkg::CMD_GET, 16'd0, 32'hFFFF_FFFF, 32'd0);
        send_item(pwt_pkg::CMD_GET, 16'hFFFF, 32'd0, 32'd0);
        send_item(pwt_pkg::CMD_SET, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(pwt_pkg::CMD_SET, 16'd1, 32'd10, 32'hFFFF_FFF0);
        send_item(pwt_pkg::CMD_GET, 16'hFFFF, 32'd0, 32'd0);
        send_item(pwt_pkg::CMD_TICK, 16'd0, 32'd0, 32'd3);
        send_item(pwt_pkg::CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(pwt_pkg::CMD_SET, 16'd1, 32'd20, 32'd0);
        send_item(pwt_pkg::CMD_SET, 16'd2, 32'd0, 32'd0);
        send_item(pwt_pkg::CMD_SET, 16'hFFFF, 32'd0, 32'd0);
        send_item(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // fill the table behind window 1, then two inserts too many
        for (int i = 0; i < pwt_pkg::MAX_TIMERS + 1; i++)
            send_item(pwt_pkg::CMD_SET, 16'(100 + i), 32'(i + 1), 32'd0);
        send_item(pwt_pkg::CMD_TICK, 16'd0, 32'd0, 32'd50);
        wait_drained();
        for (int i = 0; i < pwt_pkg::MAX_TIMERS; i++)
            send_item(pwt_pkg::CMD_SET, 16'(100 + i), 32'd0, 32'd0);
        send_item(pwt_pkg::CMD_SET, 16'd1, 32'd0, 32'd0);

        random_items(120);
        wait_drained();
        src_idle_pct = 88;
        snk_idle_pct = 23;
        random_items(120);
        wait_drained();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_items(113);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("per_window_timer_table_tb OK");
        else
            $display("per_window_timer_table_tb NOT OK");
        $finish;
    end

endmodule
